### rtl/jts_pkg.sv
// ============================================================================
// jts_pkg: shared types and constants for the JSON token scanner
// Scan modes, token kinds, word tables and the result bundle that travels
// from the scanner front end through the queue to the output stage.
// ============================================================================
package jts_pkg;

    // Field widths of the token channel
    localparam int TOKEN_W     = 32;
    localparam int KIND_W      = 3;
    localparam int TOTAL_W     = 16;
    localparam int DEPTH_W     = 16;
    localparam int MAX_RESULTS = 3;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_KEY    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STRING = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CONST  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd4;

    // Word identifiers
    localparam logic [1:0] WORD_NONE  = 2'd0;
    localparam logic [1:0] WORD_TRUE  = 2'd1;
    localparam logic [1:0] WORD_FALSE = 2'd2;
    localparam logic [1:0] WORD_NULL  = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_INT,
        MODE_FRAC,
        MODE_EXP0,
        MODE_EXPD,
        MODE_WORD
    } scan_mode_t;

    typedef struct packed {
        logic [TOKEN_W-1:0] start;
        logic [TOKEN_W-1:0] length;
        logic [KIND_W-1:0]  kind;
        logic [TOTAL_W-1:0] total;
    } token_t;

    // All results caused by one byte
    typedef struct packed {
        token_t [MAX_RESULTS-1:0] tok;
        logic [1:0]               count;
    } bundle_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [2:0] word_len(input logic [1:0] id);
        logic [2:0] len;
        case (id)
            WORD_TRUE:  len = 3'd4;
            WORD_FALSE: len = 3'd5;
            WORD_NULL:  len = 3'd4;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    // Letter k of the word, zero beyond its end
    function automatic logic [7:0] word_char(input logic [1:0] id, input logic [2:0] k);
        logic [39:0] txt;
        logic [7:0]  ch;
        case (id)
            WORD_TRUE:  txt = {8'h74, 8'h72, 8'h75, 8'h65, 8'h00};
            WORD_FALSE: txt = {8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};
            WORD_NULL:  txt = {8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00};
            default:    txt = 40'h0;
        endcase
        case (k)
            3'd0:    ch = txt[39:32];
            3'd1:    ch = txt[31:24];
            3'd2:    ch = txt[23:16];
            3'd3:    ch = txt[15:8];
            3'd4:    ch = txt[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/jts_channels.sv
// ============================================================================
// jts channels: valid/ready interfaces of the JSON token scanner
// Text input, token output and the token-limit write channel.
// ============================================================================
interface jts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jts_out_if;
    logic                          valid;
    logic                          ready;
    logic [jts_pkg::TOKEN_W-1:0]   token_start;
    logic [jts_pkg::TOKEN_W-1:0]   token_length;
    logic [jts_pkg::KIND_W-1:0]    token_kind;
    logic [jts_pkg::TOTAL_W-1:0]   token_total;
    logic                          last_of_run;

    modport source (output valid, output token_start, output token_length,
                    output token_kind, output token_total, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_start, input token_length,
                    input token_kind, input token_total, input last_of_run,
                    output ready);
endinterface

interface jts_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [jts_pkg::TOTAL_W-1:0] max_tokens;

    modport source (output valid, output max_tokens, input ready);
    modport sink   (input valid, input max_tokens, output ready);
endinterface

### rtl/jts_front.sv
// ============================================================================
// jts_front: byte scanner
// Takes one text byte per transfer, updates the lexer state and builds the
// bundle of up to three results caused by that byte.
// ============================================================================
module jts_front #(
    parameter int MAX_NESTING   = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    jts_in_if.sink              text,
    jts_cfg_if.sink             cfg,
    input  logic                q_full,
    output logic                push_valid,
    output jts_pkg::bundle_t    push_data
);

    localparam int PB = POSITION_BITS;
    localparam int LW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
    localparam logic [jts_pkg::DEPTH_W-1:0] NEST_LIMIT = jts_pkg::DEPTH_W'(MAX_NESTING);
    localparam logic [jts_pkg::DEPTH_W-1:0] DEPTH_SAT  = '1;

    // Stream state
    logic [PB-1:0]                    pos_reg, pos_next;
    logic [jts_pkg::DEPTH_W-1:0]      depth_reg, depth_next;
    logic [MAX_NESTING-1:0]           obj_reg, obj_next;
    logic                             ek_reg, ek_next;
    jts_pkg::scan_mode_t              mode_reg, mode_next;
    logic [PB-1:0]                    start_reg, start_next;
    logic [1:0]                       wid_reg, wid_next;
    logic [2:0]                       wk_reg, wk_next;
    logic [jts_pkg::TOTAL_W-1:0]      cnt_reg, cnt_next;
    logic [jts_pkg::TOTAL_W-1:0]      max_reg;

    // Working signals
    logic                             accept;
    logic [7:0]                       c;
    logic [PB-1:0]                    endx;
    logic                             do_dispatch;
    logic                             take;
    logic                             tok1_req;
    logic [PB-1:0]                    tok1_start;
    logic [PB-1:0]                    tok1_len;
    logic [jts_pkg::KIND_W-1:0]       tok1_kind;
    logic [jts_pkg::DEPTH_W-1:0]      d_up;
    logic [LW-1:0]                    lvl_up;
    logic [LW-1:0]                    lvl_cur;
    logic [2:0]                       wk_inc;
    logic [1:0]                       n;
    jts_pkg::bundle_t                 bundle;

    assign accept     = text.valid && text.ready;
    assign text.ready = !q_full;
    assign cfg.ready  = 1'b1;
    assign c          = text.text_byte;
    assign endx       = pos_reg + 1'b1;
    assign lvl_cur    = LW'(depth_reg - 1'b1);
    assign wk_inc     = wk_reg + 1'b1;

    // Next state and result bundle
    always_comb
    begin
        mode_next  = mode_reg;
        depth_next = depth_reg;
        obj_next   = obj_reg;
        ek_next    = ek_reg;
        start_next = start_reg;
        wid_next   = wid_reg;
        wk_next    = wk_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg + 1'b1;
        do_dispatch = 1'b0;
        take        = 1'b0;
        tok1_req    = 1'b0;
        tok1_start  = start_reg;
        tok1_len    = '0;
        tok1_kind   = jts_pkg::KIND_NUMBER;
        d_up        = (depth_reg != DEPTH_SAT) ? depth_reg + 1'b1 : depth_reg;
        lvl_up      = LW'(d_up - 1'b1);
        n           = 2'd0;
        bundle      = '0;

        // Byte in the current mode
        unique case (mode_reg)
            jts_pkg::MODE_IDLE:
            begin
                do_dispatch = 1'b1;
            end
            jts_pkg::MODE_STR:
            begin
                if (c == jts_pkg::CH_BSLASH)
                begin
                    mode_next = jts_pkg::MODE_ESC;
                end
                else if (c == jts_pkg::CH_QUOTE)
                begin
                    tok1_req  = 1'b1;
                    tok1_len  = endx - start_reg;
                    tok1_kind = ek_reg ? jts_pkg::KIND_KEY : jts_pkg::KIND_STRING;
                    ek_next   = 1'b0;
                    mode_next = jts_pkg::MODE_IDLE;
                end
            end
            jts_pkg::MODE_ESC:
            begin
                mode_next = jts_pkg::MODE_STR;
            end
            jts_pkg::MODE_WORD:
            begin
                if ((wk_reg < jts_pkg::word_len(wid_reg)) &&
                    (jts_pkg::word_char(wid_reg, wk_reg) == c))
                begin
                    wk_next = wk_inc;
                    if (wk_inc == jts_pkg::word_len(wid_reg))
                    begin
                        tok1_req  = 1'b1;
                        tok1_len  = PB'(wk_inc);
                        tok1_kind = jts_pkg::KIND_CONST;
                        mode_next = jts_pkg::MODE_IDLE;
                        wid_next  = jts_pkg::WORD_NONE;
                        wk_next   = 3'd0;
                    end
                end
                else
                begin
                    mode_next   = jts_pkg::MODE_IDLE;
                    wid_next    = jts_pkg::WORD_NONE;
                    wk_next     = 3'd0;
                    do_dispatch = 1'b1;
                end
            end
            default:
            begin
                // Number modes
                case (mode_reg)
                    jts_pkg::MODE_INT:
                    begin
                        if (jts_pkg::is_digit(c))
                        begin
                            take = 1'b1;
                        end
                        else if (c == jts_pkg::CH_DOT)
                        begin
                            mode_next = jts_pkg::MODE_FRAC;
                            take      = 1'b1;
                        end
                        else if (c == jts_pkg::CH_LOW_E || c == jts_pkg::CH_UP_E)
                        begin
                            mode_next = jts_pkg::MODE_EXP0;
                            take      = 1'b1;
                        end
                    end
                    jts_pkg::MODE_FRAC:
                    begin
                        if (jts_pkg::is_digit(c))
                        begin
                            take = 1'b1;
                        end
                        else if (c == jts_pkg::CH_LOW_E || c == jts_pkg::CH_UP_E)
                        begin
                            mode_next = jts_pkg::MODE_EXP0;
                            take      = 1'b1;
                        end
                    end
                    jts_pkg::MODE_EXP0:
                    begin
                        if (c == jts_pkg::CH_PLUS || c == jts_pkg::CH_MINUS ||
                            jts_pkg::is_digit(c))
                        begin
                            mode_next = jts_pkg::MODE_EXPD;
                            take      = 1'b1;
                        end
                    end
                    default:
                    begin
                        take = jts_pkg::is_digit(c);
                    end
                endcase
                if (!take)
                begin
                    tok1_req    = 1'b1;
                    tok1_len    = pos_reg - start_reg;
                    tok1_kind   = jts_pkg::KIND_NUMBER;
                    mode_next   = jts_pkg::MODE_IDLE;
                    do_dispatch = 1'b1;
                end
            end
        endcase

        // Fresh byte: structure, or the start of a token
        if (do_dispatch)
        begin
            if (c == jts_pkg::CH_LBRACE || c == jts_pkg::CH_LBRACK)
            begin
                depth_next = d_up;
                if (d_up <= NEST_LIMIT)
                begin
                    obj_next[lvl_up] = (c == jts_pkg::CH_LBRACE);
                end
                ek_next = (c == jts_pkg::CH_LBRACE);
            end
            else if (c == jts_pkg::CH_RBRACE || c == jts_pkg::CH_RBRACK)
            begin
                if (depth_reg != '0)
                begin
                    if (depth_reg <= NEST_LIMIT)
                    begin
                        obj_next[lvl_cur] = 1'b0;
                    end
                    depth_next = depth_reg - 1'b1;
                end
                if (c == jts_pkg::CH_RBRACE)
                begin
                    ek_next = 1'b0;
                end
            end
            else if (c == jts_pkg::CH_COMMA)
            begin
                if (depth_reg != '0 && depth_reg <= NEST_LIMIT && obj_reg[lvl_cur])
                begin
                    ek_next = 1'b1;
                end
            end
            else if (c == jts_pkg::CH_COLON)
            begin
                ek_next = 1'b0;
            end
            else if (c == jts_pkg::CH_QUOTE)
            begin
                mode_next  = jts_pkg::MODE_STR;
                start_next = pos_reg;
            end
            else if (c == jts_pkg::CH_MINUS || jts_pkg::is_digit(c))
            begin
                mode_next  = jts_pkg::MODE_INT;
                start_next = pos_reg;
            end
            else if (c == jts_pkg::CH_LOW_T || c == jts_pkg::CH_LOW_F ||
                     c == jts_pkg::CH_LOW_N)
            begin
                mode_next  = jts_pkg::MODE_WORD;
                start_next = pos_reg;
                wk_next    = 3'd1;
                if (c == jts_pkg::CH_LOW_T)
                begin
                    wid_next = jts_pkg::WORD_TRUE;
                end
                else if (c == jts_pkg::CH_LOW_F)
                begin
                    wid_next = jts_pkg::WORD_FALSE;
                end
                else
                begin
                    wid_next = jts_pkg::WORD_NULL;
                end
            end
        end

        // Token from this byte, subject to the limit
        if (tok1_req && cnt_next < max_reg)
        begin
            cnt_next             = cnt_next + 1'b1;
            bundle.tok[n].start  = jts_pkg::TOKEN_W'(tok1_start);
            bundle.tok[n].length = jts_pkg::TOKEN_W'(tok1_len);
            bundle.tok[n].kind   = tok1_kind;
            bundle.tok[n].total  = cnt_next;
            n                    = n + 1'b1;
        end

        // Final byte: flush an open string or number, then the end item
        if (text.end_of_text)
        begin
            if ((mode_next == jts_pkg::MODE_STR || mode_next == jts_pkg::MODE_ESC ||
                 mode_next == jts_pkg::MODE_INT || mode_next == jts_pkg::MODE_FRAC ||
                 mode_next == jts_pkg::MODE_EXP0 || mode_next == jts_pkg::MODE_EXPD) &&
                cnt_next < max_reg)
            begin
                cnt_next             = cnt_next + 1'b1;
                bundle.tok[n].start  = jts_pkg::TOKEN_W'(start_next);
                bundle.tok[n].length = jts_pkg::TOKEN_W'(endx - start_next);
                if (mode_next == jts_pkg::MODE_STR || mode_next == jts_pkg::MODE_ESC)
                begin
                    bundle.tok[n].kind = ek_next ? jts_pkg::KIND_KEY : jts_pkg::KIND_STRING;
                end
                else
                begin
                    bundle.tok[n].kind = jts_pkg::KIND_NUMBER;
                end
                bundle.tok[n].total  = cnt_next;
                n                    = n + 1'b1;
            end
            bundle.tok[n].start  = '0;
            bundle.tok[n].length = jts_pkg::TOKEN_W'(endx);
            bundle.tok[n].kind   = jts_pkg::KIND_END;
            bundle.tok[n].total  = cnt_next;
            n                    = n + 1'b1;

            // Back to the start of a new text
            pos_next   = '0;
            depth_next = '0;
            obj_next   = '0;
            ek_next    = 1'b0;
            mode_next  = jts_pkg::MODE_IDLE;
            start_next = '0;
            wid_next   = jts_pkg::WORD_NONE;
            wk_next    = 3'd0;
            cnt_next   = '0;
        end

        bundle.count = n;
    end

    assign push_valid = accept && (n != 2'd0);
    assign push_data  = bundle;

    // Scanner state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            depth_reg <= '0;
            obj_reg   <= '0;
            ek_reg    <= 1'b0;
            mode_reg  <= jts_pkg::MODE_IDLE;
            start_reg <= '0;
            wid_reg   <= jts_pkg::WORD_NONE;
            wk_reg    <= 3'd0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            depth_reg <= depth_next;
            obj_reg   <= obj_next;
            ek_reg    <= ek_next;
            mode_reg  <= mode_next;
            start_reg <= start_next;
            wid_reg   <= wid_next;
            wk_reg    <= wk_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Token limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_reg <= cfg.max_tokens;
        end
    end

    // The final byte always pushes a bundle ending in the end item
    a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && text.end_of_text) |->
            (push_valid && push_data.tok[push_data.count - 2'd1].kind == jts_pkg::KIND_END))
        else $error("final byte did not close with an end item");

    // Token count only grows within a text
    a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !text.end_of_text) |=> (cnt_reg >= $past(cnt_reg)))
        else $error("token count fell within a text");

endmodule

### rtl/jts_queue.sv
// ============================================================================
// jts_queue: result bundle queue
// Short register FIFO between the scanner and the output stage, one bundle
// per scanned byte that caused any result.
// ============================================================================
module jts_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  jts_pkg::bundle_t push_data,
    output logic             full,
    input  logic             pop,
    output jts_pkg::bundle_t head,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jts_pkg::bundle_t  mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full))
        else $error("bundle pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!empty))
        else $error("bundle popped from an empty queue");

endmodule

### rtl/jts_back.sv
// ============================================================================
// jts_back: token output stage
// Walks the results of the head bundle one per transfer and marks the last
// result of each byte.
// ============================================================================
module jts_back (
    input  logic             clk,
    input  logic             rst_n,
    input  jts_pkg::bundle_t head,
    input  logic             empty,
    output logic             pop,
    jts_out_if.source        tokens
);

    logic [1:0]     idx_reg, idx_next;
    logic           at_last;
    logic           xfer;
    jts_pkg::token_t cur;

    assign cur     = head.tok[idx_reg];
    assign at_last = (idx_reg == head.count - 2'd1);
    assign xfer    = tokens.valid && tokens.ready;
    assign pop     = xfer && at_last;

    assign tokens.valid        = !empty;
    assign tokens.token_start  = cur.start;
    assign tokens.token_length = cur.length;
    assign tokens.token_kind   = cur.kind;
    assign tokens.token_total  = cur.total;
    assign tokens.last_of_run  = at_last;

    // Result index within the head bundle
    always_comb
    begin
        idx_next = idx_reg;
        if (xfer)
        begin
            idx_next = at_last ? 2'd0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid |-> (head.count != 2'd0 && idx_reg < head.count))
        else $error("result index outside the head bundle");

endmodule

### rtl/json_token_scanner_top.sv
// ============================================================================
// json_token_scanner_top: streaming JSON lexer
// Scans text one byte per transfer and reports key, string, number and
// constant tokens, followed by an end item carrying the token count.
// ============================================================================
//
//  channel  dir  payload                                          transfer
//  -------  ---  -----------------------------------------------  -------------
//  text     in   text_byte[7:0], end_of_text                      valid & ready
//  tokens   out  token_start, token_length, token_kind,           valid & ready
//                token_total, last_of_run
//  cfg      in   max_tokens[15:0]                                 valid & ready
//
//  One byte is taken per cycle while the result queue (QUEUE_DEPTH bundles)
//  has room; a byte's bundle is registered in the queue before it is offered.
//  The output stage sends one result per cycle while tokens.ready is high, and
//  a bundle of two or three results stays at the queue head until all are sent.
//  A stall on tokens fills the queue and then drops text.ready.
//  Reset clears the stream state and sets max_tokens to 65535; no clearing pass.
//
module json_token_scanner_top #(
    parameter int MAX_NESTING   = 64,
    parameter int POSITION_BITS = 32,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    jts_in_if.sink     text,
    jts_cfg_if.sink    cfg,
    jts_out_if.source  tokens
);

    logic             push_valid;
    jts_pkg::bundle_t push_data;
    logic             q_full;
    logic             q_empty;
    logic             pop;
    jts_pkg::bundle_t head;

    // Scanner front end
    jts_front #(
        .MAX_NESTING   (MAX_NESTING),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .cfg        (cfg),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // Result queue
    jts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    // Output stage
    jts_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (q_empty),
        .pop    (pop),
        .tokens (tokens)
    );

endmodule
